[hdl/chip8_pkg.sv]
// Shared types and constants for the CHIP-8 instruction core.
// Holds request, status and opcode group codes, the font table, and the
// command and status structs between the controller and the datapath.
package chip8_pkg;

    localparam int ADDR_W    = 12;
    localparam int ROW_W     = 64;
    localparam int FONT_BYTES = 80;

    localparam logic [ADDR_W-1:0] START_PC = 12'h200;
    localparam logic [ADDR_W-1:0] OP_CLS   = 12'h0E0;
    localparam logic [ADDR_W-1:0] OP_RET   = 12'h0EE;
    localparam logic [3:0]        FLAG_REG = 4'hF;

    // Request codes.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EXEC = 2'd1;
    localparam logic [1:0] REQ_ROW  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_UNIMP = 2'd3;

    // Register file read selects.
    localparam logic [1:0] RSEL_X    = 2'd0;
    localparam logic [1:0] RSEL_Y    = 2'd1;
    localparam logic [1:0] RSEL_ZERO = 2'd2;

    // Opcode groups (top nibble).
    localparam logic [3:0] GRP_SYS    = 4'h0;
    localparam logic [3:0] GRP_JP     = 4'h1;
    localparam logic [3:0] GRP_CALL   = 4'h2;
    localparam logic [3:0] GRP_SE_I   = 4'h3;
    localparam logic [3:0] GRP_SNE_I  = 4'h4;
    localparam logic [3:0] GRP_SE_R   = 4'h5;
    localparam logic [3:0] GRP_LD_I   = 4'h6;
    localparam logic [3:0] GRP_ADD_I  = 4'h7;
    localparam logic [3:0] GRP_SNE_R  = 4'h9;
    localparam logic [3:0] GRP_LD_IDX = 4'hA;
    localparam logic [3:0] GRP_JP_V0  = 4'hB;
    localparam logic [3:0] GRP_RND    = 4'hC;
    localparam logic [3:0] GRP_DRW    = 4'hD;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic       accept;
        logic       mem_load;
        logic       fetch_hi;
        logic       fetch_lo;
        logic       cap_hi;
        logic       cap_lo;
        logic       frame_rd;
        logic [1:0] reg_sel;
        logic       cap_vx;
        logic       cap_vy;
        logic       exec;
        logic       mod_step;
        logic       draw_rd;
        logic       draw_wr;
        logic       finish;
    } c8_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] req;
        logic [3:0] grp;
        logic       n_zero;
        logic       mod_done;
        logic       draw_last;
        logic       out_free;
    } c8_stat_t;

endpackage

[hdl/chip8_ctrl.sv]
// Sequencing state machine of the CHIP-8 instruction core.
// Depends on chip8_pkg for the command and status structs and the codes.
module chip8_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  chip8_pkg::c8_stat_t stat,
    output chip8_pkg::c8_cmd_t  cmd
);
    import chip8_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_ROWRD = 4'd4;
    localparam logic [3:0] S_FHI   = 4'd5;
    localparam logic [3:0] S_FLO   = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_RDX   = 4'd8;
    localparam logic [3:0] S_RDY   = 4'd9;
    localparam logic [3:0] S_RD0   = 4'd10;
    localparam logic [3:0] S_EXEC  = 4'd11;
    localparam logic [3:0] S_MOD   = 4'd12;
    localparam logic [3:0] S_DRD   = 4'd13;
    localparam logic [3:0] S_DWR   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.reg_sel = RSEL_X;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.req)
                    REQ_LOAD: state_next = S_LOAD;
                    REQ_EXEC: state_next = S_FHI;
                    REQ_ROW:  state_next = S_ROWRD;
                    default:  state_next = S_DONE;
                endcase
            end
            S_LOAD:
            begin
                cmd.mem_load = 1'b1;
                state_next   = S_DONE;
            end
            S_ROWRD:
            begin
                cmd.frame_rd = 1'b1;
                state_next   = S_DONE;
            end
            S_FHI:
            begin
                cmd.fetch_hi = 1'b1;
                state_next   = S_FLO;
            end
            S_FLO:
            begin
                cmd.fetch_lo = 1'b1;
                cmd.cap_hi   = 1'b1;
                state_next   = S_DEC;
            end
            S_DEC:
            begin
                cmd.cap_lo = 1'b1;
                state_next = S_RDX;
            end
            S_RDX:
            begin
                cmd.reg_sel = RSEL_X;
                state_next  = S_RDY;
            end
            S_RDY:
            begin
                cmd.reg_sel = RSEL_Y;
                cmd.cap_vx  = 1'b1;
                state_next  = S_RD0;
            end
            S_RD0:
            begin
                cmd.reg_sel = RSEL_ZERO;
                cmd.cap_vy  = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.grp == GRP_DRW && !stat.n_zero)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                cmd.draw_rd = 1'b1;
                state_next  = S_DWR;
            end
            S_DWR:
            begin
                cmd.draw_wr = 1'b1;
                if (stat.draw_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DRD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[hdl/chip8_dp.sv]
// Datapath of the CHIP-8 instruction core: program memory, frame store,
// register file, return stack and the result register. Uses chip8_pkg.
module chip8_dp #(
    parameter int MEMORY_BYTES   = 4096,
    parameter int DISPLAY_WIDTH  = 64,
    parameter int DISPLAY_HEIGHT = 32,
    parameter int STACK_ENTRIES  = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  chip8_pkg::c8_cmd_t  cmd,
    output chip8_pkg::c8_stat_t stat,
    input  logic [1:0]          req_type,
    input  logic [11:0]         mem_address,
    input  logic [7:0]          mem_data,
    input  logic [7:0]          random_byte,
    input  logic [4:0]          row_select,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [63:0]         display_row,
    output logic [11:0]         pc_value,
    output logic [15:0]         opcode_value,
    output logic [7:0]          flag_value,
    output logic [1:0]          status
);
    import chip8_pkg::*;

    localparam int MA_W = $clog2(MEMORY_BYTES);
    localparam int CC_W = MA_W + 1;
    localparam int DH_W = $clog2(DISPLAY_HEIGHT);
    localparam int SP_W = $clog2(STACK_ENTRIES + 1);
    localparam int ST_W = $clog2(STACK_ENTRIES);
    localparam logic [ROW_W-1:0] WMASK = ~({ROW_W{1'b1}} >> DISPLAY_WIDTH);

    // Captured request.
    logic [1:0]        req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        data_reg;
    logic [7:0]        rnd_reg;
    logic [4:0]        row_reg;

    // Program memory and its clearing sweep.
    logic [7:0]        mem [MEMORY_BYTES];
    logic [7:0]        mem_q_reg;
    logic              mem_ok_reg;
    logic [CC_W-1:0]   clr_cnt_reg;
    logic              clr_done;
    logic [7:0]        clr_data;
    logic              mem_we;
    logic [MA_W-1:0]   mem_wa;
    logic [7:0]        mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra12;
    logic              ra_ok;
    logic              ld_ok;
    logic [7:0]        mem_byte;

    // Architectural state.
    logic [ADDR_W-1:0] pc_reg;
    logic [ADDR_W-1:0] pc_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic [SP_W-1:0]   sp_dec;
    logic [ADDR_W-1:0] stack_mem [STACK_ENTRIES];
    logic              push;
    logic [1:0]        st_reg;
    logic [1:0]        st_next;
    logic [7:0]        v_reg [16];
    logic              v_we;
    logic [3:0]        v_wa;
    logic [7:0]        v_wd;
    logic [3:0]        v_ra;
    logic [7:0]        v_rd_reg;
    logic [7:0]        vx_reg;
    logic [7:0]        vy_reg;

    // Opcode.
    logic [7:0]        op_hi_reg;
    logic [15:0]       op_reg;
    logic [3:0]        op_x;
    logic [3:0]        op_y;
    logic [3:0]        op_n;
    logic [7:0]        op_nn;
    logic [ADDR_W-1:0] op_nnn;
    logic [ADDR_W-1:0] pc_adv;
    logic [ADDR_W-1:0] pc_skip;

    // Draw.
    logic [7:0]        mx_reg;
    logic [7:0]        my_reg;
    logic [3:0]        rcnt_reg;
    logic [ROW_W-1:0]  frm_mem [DISPLAY_HEIGHT];
    logic [DISPLAY_HEIGHT-1:0] frm_vld_reg;
    logic [ROW_W-1:0]  frm_q_reg;
    logic              frm_ok_reg;
    logic [ROW_W-1:0]  frm_row;
    logic [ROW_W-1:0]  spr_mask;
    logic              coll;
    logic              frm_clr;
    logic [6:0]        row_wide;
    logic              row_ok;
    logic [DH_W-1:0]   frm_ra;
    logic [DH_W-1:0]   frm_wa;
    logic              frm_rd_any;

    // Result register.
    logic              out_valid_reg;
    logic [ROW_W-1:0]  drow_reg;
    logic [ADDR_W-1:0] pcv_reg;
    logic [15:0]       opv_reg;
    logic [7:0]        flag_reg;
    logic [1:0]        stat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= req_type;
            addr_reg <= mem_address;
            data_reg <= mem_data;
            rnd_reg  <= random_byte;
            row_reg  <= row_select;
        end
    end

    // Memory clearing after reset: font first, zeros after.
    assign clr_done = (clr_cnt_reg == CC_W'(MEMORY_BYTES));
    assign clr_data = (clr_cnt_reg < CC_W'(FONT_BYTES)) ? FONT[clr_cnt_reg[6:0]] : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (!clr_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign ld_ok  = ({1'b0, addr_reg} < 13'(MEMORY_BYTES));
    assign mem_we = !clr_done || (cmd.mem_load && ld_ok);
    assign mem_wa = !clr_done ? clr_cnt_reg[MA_W-1:0] : addr_reg[MA_W-1:0];
    assign mem_wd = !clr_done ? clr_data : data_reg;

    always_comb
    begin
        if (cmd.fetch_lo)
        begin
            mem_ra12 = pc_reg + 12'd1;
        end
        else if (cmd.draw_rd)
        begin
            mem_ra12 = idx_reg + ADDR_W'(rcnt_reg);
        end
        else
        begin
            mem_ra12 = pc_reg;
        end
    end

    assign ra_ok  = ({1'b0, mem_ra12} < 13'(MEMORY_BYTES));
    assign mem_re = (cmd.fetch_hi || cmd.fetch_lo || cmd.draw_rd) && ra_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_ra12[MA_W-1:0]];
        end
        if (cmd.fetch_hi || cmd.fetch_lo || cmd.draw_rd)
        begin
            mem_ok_reg <= ra_ok;
        end
    end

    assign mem_byte = mem_ok_reg ? mem_q_reg : 8'h00;

    // Opcode assembly.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_hi)
        begin
            op_hi_reg <= mem_byte;
        end
        if (cmd.cap_lo)
        begin
            op_reg <= {op_hi_reg, mem_byte};
        end
    end

    assign op_x    = op_reg[11:8];
    assign op_y    = op_reg[7:4];
    assign op_n    = op_reg[3:0];
    assign op_nn   = op_reg[7:0];
    assign op_nnn  = op_reg[11:0];
    assign pc_adv  = pc_reg + 12'd2;
    assign pc_skip = pc_reg + 12'd4;
    assign sp_dec  = sp_reg - 1'b1;

    // Register file read port, one address a cycle.
    always_comb
    begin
        case (cmd.reg_sel)
            RSEL_X:  v_ra = op_x;
            RSEL_Y:  v_ra = op_y;
            default: v_ra = 4'h0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        v_rd_reg <= v_reg[v_ra];
        if (cmd.cap_vx)
        begin
            vx_reg <= v_rd_reg;
        end
        if (cmd.cap_vy)
        begin
            vy_reg <= v_rd_reg;
        end
    end

    // Sprite row against the frame row.
    assign frm_row  = frm_ok_reg ? frm_q_reg : '0;
    assign spr_mask = ({mem_byte, {(ROW_W - 8){1'b0}}} >> mx_reg) & WMASK;
    assign coll     = |(frm_row & spr_mask);

    // Instruction execution.
    always_comb
    begin
        pc_next  = pc_reg;
        idx_next = idx_reg;
        sp_next  = sp_reg;
        st_next  = st_reg;
        v_we     = 1'b0;
        v_wa     = op_x;
        v_wd     = 8'h00;
        push     = 1'b0;
        frm_clr  = 1'b0;
        if (cmd.accept)
        begin
            st_next = ST_OK;
        end
        if (cmd.exec)
        begin
            pc_next = pc_adv;
            case (op_reg[15:12])
                GRP_SYS:
                begin
                    if (op_reg[11:0] == OP_CLS)
                    begin
                        frm_clr = 1'b1;
                    end
                    else if (op_reg[11:0] == OP_RET)
                    begin
                        if (sp_reg == '0)
                        begin
                            st_next = ST_UNDER;
                        end
                        else
                        begin
                            sp_next = sp_dec;
                            pc_next = stack_mem[sp_dec[ST_W-1:0]];
                        end
                    end
                    else
                    begin
                        st_next = ST_UNIMP;
                    end
                end
                GRP_JP:
                begin
                    pc_next = op_nnn;
                end
                GRP_CALL:
                begin
                    if (sp_reg == SP_W'(STACK_ENTRIES))
                    begin
                        st_next = ST_OVER;
                    end
                    else
                    begin
                        push    = 1'b1;
                        sp_next = sp_reg + 1'b1;
                        pc_next = op_nnn;
                    end
                end
                GRP_SE_I:
                begin
                    if (vx_reg == op_nn)
                    begin
                        pc_next = pc_skip;
                    end
                end
                GRP_SNE_I:
                begin
                    if (vx_reg != op_nn)
                    begin
                        pc_next = pc_skip;
                    end
                end
                GRP_SE_R:
                begin
                    if (op_n != 4'h0)
                    begin
                        st_next = ST_UNIMP;
                    end
                    else if (vx_reg == vy_reg)
                    begin
                        pc_next = pc_skip;
                    end
                end
                GRP_LD_I:
                begin
                    v_we = 1'b1;
                    v_wd = op_nn;
                end
                GRP_ADD_I:
                begin
                    v_we = 1'b1;
                    v_wd = vx_reg + op_nn;
                end
                GRP_SNE_R:
                begin
                    if (vx_reg != vy_reg)
                    begin
                        pc_next = pc_skip;
                    end
                end
                GRP_LD_IDX:
                begin
                    idx_next = op_nnn;
                end
                GRP_JP_V0:
                begin
                    pc_next = {4'h0, v_rd_reg} + op_nnn;
                end
                GRP_RND:
                begin
                    v_we = 1'b1;
                    v_wd = rnd_reg & op_nn;
                end
                GRP_DRW:
                begin
                    v_we = 1'b1;
                    v_wa = FLAG_REG;
                    v_wd = 8'h00;
                end
                default:
                begin
                    st_next = ST_UNIMP;
                end
            endcase
        end
        if (cmd.draw_wr && coll)
        begin
            v_we = 1'b1;
            v_wa = FLAG_REG;
            v_wd = 8'h01;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= START_PC;
            idx_reg <= '0;
            sp_reg  <= '0;
            st_reg  <= ST_OK;
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= 8'h00;
            end
        end
        else
        begin
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
            sp_reg  <= sp_next;
            st_reg  <= st_next;
            if (v_we)
            begin
                v_reg[v_wa] <= v_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[sp_reg[ST_W-1:0]] <= pc_adv;
        end
    end

    // Coordinate reduction and row walk of a draw.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            mx_reg   <= vx_reg;
            my_reg   <= vy_reg;
            rcnt_reg <= 4'h0;
        end
        else if (cmd.mod_step)
        begin
            if (mx_reg >= 8'(DISPLAY_WIDTH))
            begin
                mx_reg <= mx_reg - 8'(DISPLAY_WIDTH);
            end
            if (my_reg >= 8'(DISPLAY_HEIGHT))
            begin
                my_reg <= my_reg - 8'(DISPLAY_HEIGHT);
            end
        end
        else if (cmd.draw_wr)
        begin
            rcnt_reg <= rcnt_reg + 4'h1;
            my_reg   <= my_reg + 8'h01;
        end
    end

    // Frame store.
    assign row_wide   = 7'(row_reg);
    assign row_ok     = (row_wide < 7'(DISPLAY_HEIGHT));
    assign frm_wa     = my_reg[DH_W-1:0];
    assign frm_ra     = cmd.draw_rd ? my_reg[DH_W-1:0] : row_wide[DH_W-1:0];
    assign frm_rd_any = cmd.draw_rd || (cmd.frame_rd && row_ok);

    always_ff @(posedge clk)
    begin
        if (cmd.draw_wr)
        begin
            frm_mem[frm_wa] <= frm_row ^ spr_mask;
        end
        if (frm_rd_any)
        begin
            frm_q_reg <= frm_mem[frm_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frm_vld_reg <= '0;
            frm_ok_reg  <= 1'b0;
        end
        else
        begin
            if (frm_clr)
            begin
                frm_vld_reg <= '0;
            end
            else if (cmd.draw_wr)
            begin
                frm_vld_reg[frm_wa] <= 1'b1;
            end
            if (cmd.draw_rd || cmd.frame_rd)
            begin
                frm_ok_reg <= frm_rd_any && frm_vld_reg[frm_ra];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            drow_reg <= (req_reg == REQ_ROW) ? frm_row : '0;
            pcv_reg  <= pc_reg;
            opv_reg  <= (req_reg == REQ_EXEC) ? op_reg : 16'h0000;
            flag_reg <= v_reg[FLAG_REG];
            stat_reg <= (req_reg == REQ_EXEC) ? st_reg : ST_OK;
        end
    end

    assign out_valid    = out_valid_reg;
    assign display_row  = drow_reg;
    assign pc_value     = pcv_reg;
    assign opcode_value = opv_reg;
    assign flag_value   = flag_reg;
    assign status       = stat_reg;

    assign stat.clr_done  = clr_done;
    assign stat.req       = req_reg;
    assign stat.grp       = op_reg[15:12];
    assign stat.n_zero    = (op_n == 4'h0);
    assign stat.mod_done  = (mx_reg < 8'(DISPLAY_WIDTH)) && (my_reg < 8'(DISPLAY_HEIGHT));
    assign stat.draw_last = (rcnt_reg == (op_n - 4'h1))
                          || ((9'(my_reg) + 9'd1) >= 9'(DISPLAY_HEIGHT));
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

[hdl/chip8_instruction_core.sv]
// CHIP-8 instruction core: loads memory bytes, executes one instruction per
// execute beat (clear, return, jump, call, skips, set, add, set index, jump
// with offset, random AND and sprite draw) and returns display rows. Every
// accepted beat gives exactly one result beat carrying the program counter,
// the fetched opcode, VF and a status code. After reset the core writes the
// font and zeros into every program memory byte and accepts no beat until
// that sweep ends. An execute fetches opcode bytes and registers one at a
// time through single memory and register-file read ports. A draw first
// reduces the coordinates by repeated subtraction, then does a
// read-modify-write of the frame store for each sprite row. A finished
// result waits in an output register while the next beat may be accepted.
// Depends on chip8_pkg, chip8_ctrl and chip8_dp.
module chip8_instruction_core #(
    parameter int MEMORY_BYTES   = 4096,
    parameter int DISPLAY_WIDTH  = 64,
    parameter int DISPLAY_HEIGHT = 32,
    parameter int STACK_ENTRIES  = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic [7:0]  random_byte,
    input  logic [4:0]  row_select,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] display_row,
    output logic [11:0] pc_value,
    output logic [15:0] opcode_value,
    output logic [7:0]  flag_value,
    output logic [1:0]  status
);
    import chip8_pkg::*;

    c8_cmd_t  cmd;
    c8_stat_t stat;

    // The controller sequences each beat; the datapath holds the memories and architectural state.
    chip8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chip8_dp #(
        .MEMORY_BYTES   (MEMORY_BYTES),
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .STACK_ENTRIES  (STACK_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .mem_address  (mem_address),
        .mem_data     (mem_data),
        .random_byte  (random_byte),
        .row_select   (row_select),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .display_row  (display_row),
        .pc_value     (pc_value),
        .opcode_value (opcode_value),
        .flag_value   (flag_value),
        .status       (status)
    );

`ifndef SYNTHESIS
    // No beat is taken while program memory is still being initialised.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.clr_done |-> !in_ready)
        else $error("beat accepted during memory initialisation");

    // Overflow can only come from a call.
    a_over_on_call: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVER) |-> (opcode_value[15:12] == GRP_CALL))
        else $error("stack overflow reported for a non-call opcode");

    // Underflow can only come from a return.
    a_under_on_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDER) |-> (opcode_value == {GRP_SYS, OP_RET}))
        else $error("stack underflow reported for a non-return opcode");
`endif

endmodule
